// ----- rtl/core/kabf_pkg.sv -----
// Package for the angle/bias Kalman filter: formats, register addresses and
// shared constants. No dependencies.
package kabf_pkg;

  localparam int FRAC = 24;
  localparam int CFG_W = 31;
  localparam int IN_W = 88;
  localparam int OUT_W = 64;
  localparam int ADDR_W = 4;

  localparam logic [ADDR_W-1:0] ADDR_ANGLE_NOISE = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_BIAS_NOISE = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_MEASURE_NOISE = 4'h8;

  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 31'd16777;
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST = 31'd50332;
  localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = 31'd503316;

endpackage

// ----- rtl/core/kabf_div.sv -----
// Bit-serial restoring divider: ((|n| << 24) + d/2) / d, signed result,
// saturated to W bits. One quotient bit per cycle. Uses kabf_pkg.
module kabf_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int NW = W + kabf_pkg::FRAC + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dividend;
  logic [NW-1:0] q;
  logic [W:0] rem;
  logic [CW-1:0] cnt;
  logic busy;
  logic neg;
  logic [W-1:0] dabs;
  logic [W:0] trial;
  logic [W-1:0] mn;
  logic [W-1:0] lim;

  assign mn = num[W-1] ? (~num + 1'b1) : num;
  assign trial = {rem[W-1:0], dividend[NW-1]};
  assign lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      neg <= num[W-1];
      dabs <= den;
      dividend <= ({1'b0, mn, {kabf_pkg::FRAC{1'b0}}}) + NW'(den >> 1);
      rem <= '0;
      q <= '0;
      cnt <= CW'(NW);
    end else if (busy) begin
      if (trial >= {1'b0, dabs}) begin
        rem <= trial - {1'b0, dabs};
        q <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[NW-2:0], 1'b0};
      end
      dividend <= {dividend[NW-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // saturate magnitude, apply sign
  always_comb begin
    logic [NW-1:0] mq;
    mq = q;
    if (mq > NW'(lim)) mq = NW'(lim);
    quo = neg ? (~mq[W-1:0] + 1'b1) : mq[W-1:0];
  end
endmodule

// ----- rtl/core/kalman_angle_bias_filter.sv -----
// Top level of the two-state angle/gyro-bias Kalman filter.
// Uses kabf_pkg and kabf_div.
//
// Usage: one input transfer on s_axis (angle_meas, rate_meas, step_time)
// gives one output transfer on m_axis (filtered_angle, filtered_bias).
// The filter runs its update through one shared multiplier (one product a
// cycle in the compute steps, registered) and a bit-serial divider under a
// small sequencer. An item takes 27 multiply/add steps plus two divisions,
// each made of a start, DATA_WIDTH+25 quotient bits and a hand-over. When
// the innovation variance is not positive the divisions are skipped.
// s_axis_tready is high only while the sequencer is idle. The result waits
// in the output register while m_axis stalls; the next item is accepted and
// computed meanwhile, and the sequencer holds only if the older result is
// still waiting when the new one is ready.
// Noise registers are written over the APB port at 0x0, 0x4, 0x8; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Reads return them. Reset (rst, synchronous) clears the angle,
// bias and covariance state to zero and restores the noise defaults.
module kalman_angle_bias_filter #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // angle_meas[31:0], rate_meas[63:32], step_time[87:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // filtered_angle[31:0], filtered_bias[63:32]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int W = DATA_WIDTH;
  localparam int FR = kabf_pkg::FRAC;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_POST = 4'b1000
  } state_t;

  typedef enum logic [4:0] {
    OP_MUL, OP_ADD, OP_SUB
  } op_t;

  state_t state;
  logic [4:0] step;

  logic [30:0] angle_noise, bias_noise, measure_noise;
  logic signed [W-1:0] angle_est, bias_est, cov_aa, cov_ab, cov_ba, cov_bb;
  logic signed [W-1:0] zmeas, rmeas, dt, t, s, k0, k1, y, p00, p01, acc;

  // ---- APB ----
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise <= kabf_pkg::ANGLE_NOISE_RST;
      bias_noise <= kabf_pkg::BIAS_NOISE_RST;
      measure_noise <= kabf_pkg::MEASURE_NOISE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        kabf_pkg::ADDR_ANGLE_NOISE:   angle_noise <= pwdata[30:0];
        kabf_pkg::ADDR_BIAS_NOISE:    bias_noise <= pwdata[30:0];
        kabf_pkg::ADDR_MEASURE_NOISE: measure_noise <= pwdata[30:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr)
      kabf_pkg::ADDR_ANGLE_NOISE:   prdata = {1'b0, angle_noise};
      kabf_pkg::ADDR_BIAS_NOISE:    prdata = {1'b0, bias_noise};
      kabf_pkg::ADDR_MEASURE_NOISE: prdata = {1'b0, measure_noise};
      default:                      prdata = '0;
    endcase
  end

  // ---- shared ALU: saturating add/sub or rounded Q24 multiply ----
  op_t op;
  logic signed [W-1:0] opa, opb, res;

  function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] v);
    if (v > (W+2)'(MAXV)) return MAXV;
    if (v < (W+2)'(MINV)) return MINV;
    return v[W-1:0];
  endfunction

  // clamp of a 31-bit unsigned register into W bits
  function automatic logic signed [W-1:0] fitu(input logic [30:0] v);
    logic [63:0] e;
    e = 64'(v);
    if (e > 64'(MAXV)) return MAXV;
    return W'(e);
  endfunction

  // 32-bit input word into W bits
  function automatic logic signed [W-1:0] fit32(input logic [31:0] v);
    logic signed [63:0] e;
    e = 64'(signed'(v));
    if (e > 64'(MAXV)) return MAXV;
    if (e < 64'(MINV)) return MINV;
    return W'(e);
  endfunction

  always_comb begin
    logic neg;
    logic [W-1:0] ma, mb, lim;
    logic [2*W-1:0] pr;
    logic [2*W-1:0] sh;
    neg = opa[W-1] ^ opb[W-1];
    ma = opa[W-1] ? W'(-opa) : opa;
    mb = opb[W-1] ? W'(-opb) : opb;
    pr = ma * mb;
    sh = (pr + (2*W)'(1 << (FR-1))) >> FR;
    lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    if (sh > (2*W)'(lim)) sh = (2*W)'(lim);
    case (op)
      OP_ADD: res = sat((W+2)'(opa) + (W+2)'(opb));
      OP_SUB: res = sat((W+2)'(opa) - (W+2)'(opb));
      OP_MUL: res = neg ? W'(-sh[W-1:0]) : sh[W-1:0];
      default: res = '0;
    endcase
  end

  // ---- divider ----
  logic div_start, div_done;
  logic [W-1:0] div_q, div_num;
  kabf_div #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(s), .done(div_done), .quo(div_q)
  );
  logic div_sel;

  // ---- step table: operands and op for each compute step ----
  always_comb begin
    op = OP_MUL; opa = dt; opb = '0;
    case (step)
      5'd0:  begin op = OP_SUB; opa = rmeas; opb = bias_est; end
      5'd1:  begin op = OP_MUL; opa = dt; opb = acc; end
      5'd2:  begin op = OP_ADD; opa = angle_est; opb = acc; end
      5'd3:  begin op = OP_MUL; opa = dt; opb = cov_bb; end
      5'd4:  begin op = OP_SUB; opa = acc; opb = cov_ab; end
      5'd5:  begin op = OP_SUB; opa = acc; opb = cov_ba; end
      5'd6:  begin op = OP_ADD; opa = acc; opb = fitu(angle_noise); end
      5'd7:  begin op = OP_MUL; opa = dt; opb = acc; end
      5'd8:  begin op = OP_ADD; opa = cov_aa; opb = acc; end
      5'd9:  begin op = OP_SUB; opa = cov_ab; opb = t; end
      5'd10: begin op = OP_SUB; opa = cov_ba; opb = t; end
      5'd11: begin op = OP_MUL; opa = fitu(bias_noise); opb = dt; end
      5'd12: begin op = OP_ADD; opa = cov_bb; opb = acc; end
      5'd13: begin op = OP_ADD; opa = cov_aa; opb = fitu(measure_noise); end
      // after division
      5'd14: begin op = OP_SUB; opa = zmeas; opb = angle_est; end
      5'd15: begin op = OP_MUL; opa = k0; opb = y; end
      5'd16: begin op = OP_ADD; opa = angle_est; opb = acc; end
      5'd17: begin op = OP_MUL; opa = k1; opb = y; end
      5'd18: begin op = OP_ADD; opa = bias_est; opb = acc; end
      5'd19: begin op = OP_MUL; opa = k0; opb = p00; end
      5'd20: begin op = OP_SUB; opa = p00; opb = acc; end
      5'd21: begin op = OP_MUL; opa = k0; opb = p01; end
      5'd22: begin op = OP_SUB; opa = p01; opb = acc; end
      5'd23: begin op = OP_MUL; opa = k1; opb = p00; end
      5'd24: begin op = OP_SUB; opa = cov_ba; opb = acc; end
      5'd25: begin op = OP_MUL; opa = k1; opb = p01; end
      5'd26: begin op = OP_SUB; opa = cov_bb; opb = acc; end
      default: ;
    endcase
  end

  assign div_num = div_sel ? cov_ba : cov_aa;
  assign s_axis_tready = (state == S_IDLE);

  function automatic logic [31:0] out32(input logic signed [W-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    if (e > 64'sd2147483647) return 32'h7fffffff;
    if (e < -64'sd2147483648) return 32'h80000000;
    return e[31:0];
  endfunction

  // output register: loads in S_POST when empty or being emptied this cycle
  logic out_load;
  assign out_load = (state == S_POST) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tdata <= {out32(bias_est), out32(angle_est)};
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      div_sel <= 1'b0;
      angle_est <= '0; bias_est <= '0;
      cov_aa <= '0; cov_ab <= '0; cov_ba <= '0; cov_bb <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            zmeas <= fit32(s_axis_tdata[31:0]);
            rmeas <= fit32(s_axis_tdata[63:32]);
            dt <= fitu(31'(s_axis_tdata[87:64]));
            step <= '0;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          acc <= res;
          step <= step + 1'b1;
          case (step)
            5'd2:  angle_est <= res;
            5'd3:  t <= res;
            5'd8:  cov_aa <= res;
            5'd9:  cov_ab <= res;
            5'd10: cov_ba <= res;
            5'd12: cov_bb <= res;
            5'd13: begin
              s <= res;
              p00 <= cov_aa;
              p01 <= cov_ab;
              k0 <= '0; k1 <= '0;
              if (!res[W-1] && res != '0) begin
                div_sel <= 1'b0;
                div_start <= 1'b1;
                state <= S_DIV;
              end
            end
            5'd14: y <= res;
            5'd16: angle_est <= res;
            5'd18: bias_est <= res;
            5'd20: cov_aa <= res;
            5'd22: cov_ab <= res;
            5'd24: cov_ba <= res;
            5'd26: begin
              cov_bb <= res;
              state <= S_POST;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            if (!div_sel) begin
              k0 <= div_q;
              div_sel <= 1'b1;
              div_start <= 1'b1;
            end else begin
              k1 <= div_q;
              state <= S_CALC;
            end
          end
        end
        S_POST: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
